// File: hdl/fpr_pkg.sv
// Shared types and constants for the FIFO page replacement block.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int MAX_FRAMES = 128;
  localparam int PAGE_BITS  = 8;

  // Frame count register holds 0..MAX_FRAMES.
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // Cells are reduced in groups, then across groups.
  localparam int GROUP     = 8;
  localparam int NGROUPS   = (MAX_FRAMES + GROUP - 1) / GROUP;
  localparam int NCELLS_PD = NGROUPS * GROUP;

  localparam int FAULT_W   = 16;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    page_t page;
    logic  valid;
    logic  last;
  } cell_link_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic kill;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_REDUCE,
    ST_UPDATE
  } state_e;

endpackage

// File: hdl/fpr_cell.sv
// One frame cell: holds a page and its valid bit, compares and shifts.
`timescale 1ns / 1ps

module fpr_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpr_pkg::cell_ctrl_t ctrl_i,
  input  fpr_pkg::cell_link_t prev_i,
  input  logic               next_valid_i,
  input  fpr_pkg::page_t     query_i,
  output fpr_pkg::cell_link_t link_o,
  output logic               match_o
);

  fpr_pkg::page_t page_q;
  logic           valid_q;

  // On an evicting fault the oldest entry moves into this cell but is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= prev_i.valid && !(ctrl_i.kill && prev_i.last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      page_q <= prev_i.page;
    end
  end

  assign match_o     = valid_q && (page_q == query_i);
  assign link_o.page  = page_q;
  assign link_o.valid = valid_q;
  assign link_o.last  = valid_q && !next_valid_i;

endmodule

// File: hdl/fpr_group.sv
// Registered reduction over one group of cells: any match and the oldest page.
`timescale 1ns / 1ps

module fpr_group (
  input  logic                                  clk_i,
  input  logic [fpr_pkg::GROUP-1:0]             match_i,
  input  logic [fpr_pkg::GROUP-1:0]             last_i,
  input  fpr_pkg::page_t [fpr_pkg::GROUP-1:0]   page_i,
  output logic                                  hit_o,
  output fpr_pkg::page_t                        page_o
);

  logic           hit_d;
  fpr_pkg::page_t page_d;

  // At most one cell in the whole row is last, so an OR selects it.
  always_comb begin
    hit_d  = 1'b0;
    page_d = '0;
    for (int i = 0; i < fpr_pkg::GROUP; i++) begin
      hit_d  = hit_d | match_i[i];
      page_d = page_d | (last_i[i] ? page_i[i] : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o  <= hit_d;
    page_o <= page_d;
  end

endmodule

// File: hdl/fifo_page_replacement.sv
// FIFO page replacement top level: frame cell row, reduction and control.
// A word accepted in the idle state passes the compare, two-level reduction and update
// states and is registered on the outputs when the update commits, which waits while a
// held result is stalled. No new word is taken until the last one has committed.
// Reset clears all frames, the fault count and sets the frame count to 1.
`timescale 1ns / 1ps

module fifo_page_replacement (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [7:0]              cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              page_i,
  input  logic                    restart_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    fault_o,
  output logic                    evict_valid_o,
  output logic [7:0]              evicted_page_o,
  output logic [15:0]             fault_total_o
);

  fpr_pkg::state_e state_q, state_d;

  fpr_pkg::page_t                    query_q;
  logic [fpr_pkg::CNT_W-1:0]         cap_q, cap_d;
  logic [fpr_pkg::CNT_W-1:0]         count_q;
  logic [fpr_pkg::FAULT_W-1:0]       faults_q;

  logic                              hit_q;
  fpr_pkg::page_t                    oldest_q;

  logic                              out_valid_q;
  logic                              out_fault_q;
  logic                              out_evict_q;
  fpr_pkg::page_t                    out_page_q;

  logic                              accept;
  logic                              commit;
  logic                              fault;
  logic                              evict;
  fpr_pkg::cell_ctrl_t               ctrl;

  fpr_pkg::cell_link_t [fpr_pkg::NCELLS_PD-1:0] links;
  logic [fpr_pkg::NCELLS_PD-1:0]                cell_match;
  logic [fpr_pkg::NCELLS_PD-1:0]                lasts;
  fpr_pkg::page_t [fpr_pkg::NCELLS_PD-1:0]      pages;

  logic [fpr_pkg::NGROUPS-1:0]                  g_hit;
  fpr_pkg::page_t [fpr_pkg::NGROUPS-1:0]        g_page;
  logic                                         hit_d;
  fpr_pkg::page_t                               oldest_d;

  assign accept = in_valid_i && !in_stall_o;
  assign commit = (state_q == fpr_pkg::ST_UPDATE) && (!out_valid_q || !out_stall_i);
  assign fault  = !hit_q;
  assign evict  = fault && (count_q >= cap_q);

  assign ctrl.clear = accept && restart_i;
  assign ctrl.shift = commit && fault;
  assign ctrl.kill  = evict;

  // Frame cell row; cell 0 takes the new page.
  for (genvar i = 0; i < fpr_pkg::NCELLS_PD; i++) begin : g_cells
    if (i < fpr_pkg::MAX_FRAMES) begin : g_real
      fpr_pkg::cell_link_t prev;
      logic                next_valid;

      if (i == 0) begin : g_head
        assign prev.page  = query_q;
        assign prev.valid = 1'b1;
        assign prev.last  = 1'b0;
      end else begin : g_body
        assign prev = links[i-1];
      end

      if (i == fpr_pkg::MAX_FRAMES - 1) begin : g_tail
        assign next_valid = 1'b0;
      end else begin : g_mid
        assign next_valid = links[i+1].valid;
      end

      fpr_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .prev_i       (prev),
        .next_valid_i (next_valid),
        .query_i      (query_q),
        .link_o       (links[i]),
        .match_o      (cell_match[i])
      );
    end else begin : g_pad
      assign links[i]      = '0;
      assign cell_match[i] = 1'b0;
    end
    assign lasts[i] = links[i].last;
    assign pages[i] = links[i].page;
  end

  for (genvar g = 0; g < fpr_pkg::NGROUPS; g++) begin : g_groups
    fpr_group u_group (
      .clk_i   (clk_i),
      .match_i (cell_match[g*fpr_pkg::GROUP +: fpr_pkg::GROUP]),
      .last_i  (lasts[g*fpr_pkg::GROUP +: fpr_pkg::GROUP]),
      .page_i  (pages[g*fpr_pkg::GROUP +: fpr_pkg::GROUP]),
      .hit_o   (g_hit[g]),
      .page_o  (g_page[g])
    );
  end

  always_comb begin
    hit_d    = 1'b0;
    oldest_d = '0;
    for (int g = 0; g < fpr_pkg::NGROUPS; g++) begin
      hit_d    = hit_d | g_hit[g];
      oldest_d = oldest_d | g_page[g];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    oldest_q <= oldest_d;
    if (accept) begin
      query_q <= fpr_pkg::PAGE_BITS'(page_i);
    end
  end

  // Frame count is clamped to 1..MAX_FRAMES when written.
  always_comb begin
    if (cfg_data_i == 8'd0) begin
      cap_d = fpr_pkg::CNT_W'(1);
    end else if (32'(cfg_data_i) > 32'(fpr_pkg::MAX_FRAMES)) begin
      cap_d = fpr_pkg::CNT_W'(fpr_pkg::MAX_FRAMES);
    end else begin
      cap_d = fpr_pkg::CNT_W'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= fpr_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      cap_q <= cap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      faults_q <= '0;
    end else if (ctrl.clear) begin
      count_q  <= '0;
      faults_q <= '0;
    end else if (ctrl.shift) begin
      if (!evict) begin
        count_q <= count_q + fpr_pkg::CNT_W'(1);
      end
      if (faults_q != '1) begin
        faults_q <= faults_q + fpr_pkg::FAULT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    case (state_q)
      fpr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = fpr_pkg::ST_COMPARE;
        end
      end
      fpr_pkg::ST_COMPARE: state_d = fpr_pkg::ST_REDUCE;
      fpr_pkg::ST_REDUCE:  state_d = fpr_pkg::ST_UPDATE;
      fpr_pkg::ST_UPDATE: begin
        if (commit) begin
          state_d = fpr_pkg::ST_IDLE;
        end
      end
      default: state_d = fpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_fault_q <= fault;
      out_evict_q <= evict;
      out_page_q  <= evict ? oldest_q : '0;
    end
  end

  // The count register takes this word's fault at the same commit, so the total adds it here.
  logic [fpr_pkg::FAULT_W-1:0] total_q;
  always_ff @(posedge clk_i) begin
    if (commit) begin
      total_q <= (fault && faults_q != '1) ? faults_q + fpr_pkg::FAULT_W'(1) : faults_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fault_o        = out_fault_q;
  assign evict_valid_o  = out_evict_q;
  assign evicted_page_o = 8'(out_page_q);
  assign fault_total_o  = total_q;

endmodule

// File: hdl/fpr_checker.sv
// Port-level checks for the FIFO page replacement block, bound to its top level.
`timescale 1ns / 1ps

module fpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        fault_o,
  input logic        evict_valid_o,
  input logic [7:0]  evicted_page_o,
  input logic [15:0] fault_total_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fault_o) &&
      $stable(evict_valid_o) && $stable(evicted_page_o) && $stable(fault_total_o))
    else $error("stalled result changed");

  // Only one word is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evict_valid_o |-> fault_o && (fault_total_o != 16'd0))
    else $error("eviction without a fault");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evict_valid_o |-> evicted_page_o == 8'd0)
    else $error("evicted page not zero without eviction");

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .fault_o        (fault_o),
  .evict_valid_o  (evict_valid_o),
  .evicted_page_o (evicted_page_o),
  .fault_total_o  (fault_total_o)
);

// File: tb/tb_top.sv
// Self-checking testbench for the FIFO page replacement block.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [7:0] page;
    logic       restart;
  } page_ref_t;

  typedef struct packed {
    logic        fault;
    logic        evict_valid;
    logic [7:0]  evicted_page;
    logic [15:0] fault_total;
  } ref_outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [7:0]  page = 8'd0;
  logic        restart = 1'b0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic        fault_o;
  logic        evict_valid_o;
  logic [7:0]  evicted_page_o;
  logic [15:0] fault_total_o;

  // Stimulus and expected outcomes.
  page_ref_t    refs_to_send[$];
  ref_outcome_t outcomes_due[$];

  // Shadow copy of the replacement state, newest page at the front.
  logic [7:0]  resident_pages[$];
  logic [15:0] fault_count = 16'd0;
  logic [7:0]  frame_limit = 8'd1;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  bit   idle_on = 1'b1;
  int   send_hold = 0;
  int   recv_hold = 0;
  int   mismatches = 0;

  logic [7:0] frame_plan [10] = '{8'd2, 8'd4, 8'd128, 8'd0, 8'd1, 8'd16, 8'd255, 8'd3,
                                  8'd5, 8'd8};

  fifo_page_replacement u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .page_i         (page),
    .restart_i      (restart),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .fault_o        (fault_o),
    .evict_valid_o  (evict_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_total_o  (fault_total_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Applies one reference to the shadow state and queues the outcome it should give.
  task automatic fifo_replace(input logic [7:0] pg, input logic rs);
    ref_outcome_t r;
    int cap;
    int oldest;
    bit hit;
    if (rs) begin
      resident_pages.delete();
      fault_count = 16'd0;
    end
    hit = 1'b0;
    foreach (resident_pages[k]) if (resident_pages[k] == pg) hit = 1'b1;
    r = '0;
    r.fault = !hit;
    if (!hit) begin
      if (fault_count != 16'hFFFF) fault_count++;
      cap = (frame_limit == 0) ? 1 :
            ((frame_limit > fpr_pkg::MAX_FRAMES) ? fpr_pkg::MAX_FRAMES : frame_limit);
      // Only the oldest page leaves, even when the limit was lowered below residency.
      if (resident_pages.size() + 1 > cap) begin
        oldest = resident_pages.size() - 1;
        r.evict_valid  = 1'b1;
        r.evicted_page = resident_pages[oldest];
        resident_pages.delete(oldest);
      end
      resident_pages.push_front(pg);
    end
    r.fault_total = fault_count;
    outcomes_due.push_back(r);
  endtask

  always @(posedge clk_i) begin
    ref_outcome_t want;
    if (rst_ni) begin
      in_fire  <= in_valid && !in_stall_o;
      out_fire <= out_valid_o && !out_stall;
      if (out_valid_o && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with nothing outstanding, fault_total", fault_total_o, 0);
        end else begin
          want = outcomes_due.pop_front();
          if (fault_o !== want.fault) report_mismatch("fault", fault_o, want.fault);
          if (evict_valid_o !== want.evict_valid)
            report_mismatch("evict_valid", evict_valid_o, want.evict_valid);
          if (evicted_page_o !== want.evicted_page)
            report_mismatch("evicted_page", evicted_page_o, want.evicted_page);
          if (fault_total_o !== want.fault_total)
            report_mismatch("fault_total", fault_total_o, want.fault_total);
        end
      end
      if (in_valid && !in_stall_o) fifo_replace(page, restart);
    end
  end

  // Sender: presents the next word once the current one is taken and its gap has run out.
  always @(negedge clk_i) begin
    page_ref_t nxt;
    if (rst_ni && (!in_valid || in_fire)) begin
      if (send_hold != 0) begin
        in_valid  <= 1'b0;
        send_hold <= send_hold - 1;
      end else if (refs_to_send.size() != 0) begin
        nxt = refs_to_send.pop_front();
        in_valid  <= 1'b1;
        page      <= nxt.page;
        restart   <= nxt.restart;
        send_hold <= idle_on ? $urandom_range(0, 19) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: after every word it takes, stalls for a fresh random count while idle gaps are on.
  always @(negedge clk_i) begin
    int hold;
    if (rst_ni) begin
      hold = out_fire ? (idle_on ? $urandom_range(0, 19) : 0) : recv_hold;
      out_stall <= (hold != 0);
      recv_hold <= (hold != 0) ? hold - 1 : 0;
    end
  end

  task automatic add_ref(input logic [7:0] pg, input logic rs);
    page_ref_t r;
    r.page    = pg;
    r.restart = rs;
    refs_to_send.push_back(r);
  endtask

  task automatic drain();
    while (refs_to_send.size() != 0 || in_valid || outcomes_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_frames(input logic [7:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    frame_limit = value;
  endtask

  task automatic random_phase(input logic [7:0] frames);
    int eff;
    int pool;
    int n;
    int base;
    logic [7:0] pg;
    logic rs;
    drain();
    program_frames(frames);
    idle_on = ($urandom_range(0, 3) != 0);
    eff  = (frames == 0) ? 1 :
           ((frames > fpr_pkg::MAX_FRAMES) ? fpr_pkg::MAX_FRAMES : frames);
    n    = (eff >= 64) ? 150 : 20;
    base = $urandom_range(0, 255);
    pool = eff + $urandom_range(0, eff + 2);
    if (pool > 255) pool = 255;
    for (int k = 0; k < n; k++) begin
      if (eff >= 64) begin
        // Mostly fresh pages so that a large frame set fills and starts to evict.
        pg = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'(base + k);
        rs = ($urandom_range(0, 199) == 0);
      end else begin
        pg = 8'($urandom_range(0, pool));
        rs = ($urandom_range(0, 15) == 0);
      end
      add_ref(pg, rs);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset frame count of one: hit, miss with eviction, restart.
    add_ref(8'd0, 1'b0);
    add_ref(8'd0, 1'b0);
    add_ref(8'd255, 1'b0);
    add_ref(8'd255, 1'b0);
    add_ref(8'd0, 1'b1);
    drain();

    // A frame count of zero behaves as one.
    program_frames(8'd0);
    add_ref(8'd170, 1'b0);
    add_ref(8'd85, 1'b0);
    add_ref(8'd85, 1'b0);
    add_ref(8'd85, 1'b1);
    drain();

    program_frames(8'd3);
    add_ref(8'd1, 1'b1);
    add_ref(8'd2, 1'b0);
    add_ref(8'd3, 1'b0);
    add_ref(8'd1, 1'b0);
    add_ref(8'd4, 1'b0);
    add_ref(8'd2, 1'b0);
    add_ref(8'd5, 1'b0);
    drain();

    // Lower the limit with three pages still resident.
    program_frames(8'd1);
    add_ref(8'd4, 1'b0);
    add_ref(8'd9, 1'b0);
    add_ref(8'd5, 1'b0);
    add_ref(8'd10, 1'b0);
    add_ref(8'd11, 1'b0);

    foreach (frame_plan[k]) begin
      if (k == 8) random_phase(8'($urandom_range(0, 63)));
      else random_phase(frame_plan[k]);
    end
    drain();

    if (outcomes_due.size() != 0) report_mismatch("results never seen", outcomes_due.size(), 0);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
hdl/fpr_pkg.sv
hdl/fpr_cell.sv
hdl/fpr_group.sv
hdl/fifo_page_replacement.sv
hdl/fpr_checker.sv
tb/tb_top.sv
